/* rtl/icr_pkg.sv */
// Shared widths, constants and saturation helper for the impulse collision response block.
// No dependencies; imported by the top level and its checker.
package icr_pkg;

    localparam int Q_FRAC   = 16;
    localparam int ONE_Q    = 65536;
    localparam int VAL_W    = 32;
    localparam int MASS_W   = 31;
    localparam int ELAST_W  = 17;
    localparam int NORM_W   = 18;
    localparam int DEPTH_W  = 31;
    localparam int DIV_QW   = 32;
    localparam int IN_W     = 296;
    localparam int OUT_W    = 256;

    // clamp to signed 32 bits
    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (x > hi)
            return 32'sh7FFF_FFFF;
        else if (x < lo)
            return 32'sh8000_0000;
        else
            return x[VAL_W-1:0];
    endfunction

endpackage

/* rtl/icr_div.sv */
// Pipelined restoring divider, one quotient bit per register stage, with a sideband.
// Standalone; instantiated by impulse_collision_response_top.
module icr_div #(
    parameter int DW = 32,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] den,
    input  logic [DW-1:0] rem0,     // upper numerator bits, must be below den
    input  logic [QW-1:0] num_lo,
    input  logic [SW-1:0] side_in,
    output logic [QW-1:0] quot,
    output logic [SW-1:0] side_out
);

    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] w_reg    [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_i;
        logic [QW-1:0] w_i;
        logic [DW-1:0] den_i;
        logic [SW-1:0] side_i;
        logic [DW:0]   t;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] w_next;

        if (k == 0) begin : g_first
            assign rem_i  = rem0;
            assign w_i    = num_lo;
            assign den_i  = den;
            assign side_i = side_in;
        end else begin : g_rest
            assign rem_i  = rem_reg[k-1];
            assign w_i    = w_reg[k-1];
            assign den_i  = den_reg[k-1];
            assign side_i = side_reg[k-1];
        end

        // shift in the next numerator bit, subtract when it fits
        always_comb
        begin
            t        = {rem_i, w_i[QW-1]};
            diff     = t - {1'b0, den_i};
            ge       = (t >= {1'b0, den_i});
            rem_next = ge ? diff[DW-1:0] : t[DW-1:0];
            w_next   = {w_i[QW-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                w_reg[k]    <= w_next;
                den_reg[k]  <= den_i;
                side_reg[k] <= side_i;
            end
        end
    end

    assign quot     = w_reg[QW-1];
    assign side_out = side_reg[QW-1];

endmodule

/* rtl/impulse_collision_response_top.sv */
// Top level of the 2D impulse collision response pipeline.
// Depends on icr_pkg and icr_div.
//
// Usage:
//   Present one contact per transfer on the s_ channel: two Q16.16 velocities,
//   inverse masses, restitutions, the unit normal from A to B and the
//   penetration depth, all with 16 fraction bits. Each contact gives one
//   transfer on the m_ channel: updated velocities and position corrections
//   in tdata, and in tuser a flag set when both bodies are static; such a
//   contact passes its velocities through and reports zero corrections.
// Stages: the five front stages, the 32 stages of the dividers and the five
//   back stages lie between the input transfer and m_tvalid.
// Throughput: one contact per cycle. All stages advance together; the
//   pipeline holds as a whole only when the output register is full and the
//   receiver does not take it, so a stall drops and repeats nothing.
// Reset: rst_n clears every valid bit at once; the first contact may be sent
//   on the cycle after rst_n rises. The payload registers are not reset.
module impulse_collision_response_top
    import icr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // vel_a_x, vel_a_y, vel_b_x, vel_b_y, inv_mass_a, inv_mass_b,
    // elast_a, elast_b, normal_x, normal_y, depth; zero pad to 296 bits
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y,
    // shift_a_x, shift_a_y, shift_b_x, shift_b_y
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tuser    // both_static
);

    typedef struct packed {
        logic signed [VAL_W-1:0]  va_x;
        logic signed [VAL_W-1:0]  va_y;
        logic signed [VAL_W-1:0]  vb_x;
        logic signed [VAL_W-1:0]  vb_y;
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic [MASS_W-1:0]        ia;
        logic [MASS_W-1:0]        ib;
        logic                     stat;
    } body_t;

    typedef struct packed {
        body_t body;
        logic  jneg;
        logic  jovf;
        logic  neg_ax;
        logic  neg_ay;
        logic  neg_bx;
        logic  neg_by;
    } side_t;

    localparam int SW = $bits(side_t);

    // advance the whole pipeline unless the output is held
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------- stage 1: unpack, velocity difference, denominator
    body_t                    b1_reg, b1_next;
    logic signed [VAL_W:0]    dvx1_reg, dvx1_next, dvy1_reg, dvy1_next;
    logic [VAL_W-1:0]         den1_reg, den1_next;
    logic [ELAST_W:0]         e1_reg, e1_next;
    logic [DEPTH_W-1:0]       dep1_reg, dep1_next;
    logic                     v1_reg;

    always_comb
    begin
        logic [ELAST_W-1:0] ea;
        logic [ELAST_W-1:0] eb;
        b1_next.va_x = s_tdata[31:0];
        b1_next.va_y = s_tdata[63:32];
        b1_next.vb_x = s_tdata[95:64];
        b1_next.vb_y = s_tdata[127:96];
        b1_next.ia   = s_tdata[158:128];
        b1_next.ib   = s_tdata[189:159];
        ea           = s_tdata[206:190];
        eb           = s_tdata[223:207];
        b1_next.nx   = s_tdata[241:224];
        b1_next.ny   = s_tdata[259:242];
        dep1_next    = s_tdata[290:260];
        den1_next    = {1'b0, b1_next.ia} + {1'b0, b1_next.ib};
        b1_next.stat = (den1_next == '0);
        e1_next      = (ELAST_W+1)'(ONE_Q) + {1'b0, ((ea < eb) ? ea : eb)};
        dvx1_next    = {b1_next.vb_x[VAL_W-1], b1_next.vb_x}
                     - {b1_next.va_x[VAL_W-1], b1_next.va_x};
        dvy1_next    = {b1_next.vb_y[VAL_W-1], b1_next.vb_y}
                     - {b1_next.va_y[VAL_W-1], b1_next.va_y};
    end

    // ---------------- stage 2: normal products
    body_t                    b2_reg;
    logic signed [50:0]       pvx2_reg, pvy2_reg;
    logic signed [49:0]       pdx2_reg, pdy2_reg;
    logic [VAL_W-1:0]         den2_reg;
    logic [ELAST_W:0]         e2_reg;
    logic                     v2_reg;

    // ---------------- stage 3: normal speed and depth vector
    body_t                    b3_reg;
    logic signed [35:0]       vn3_reg, vn3_next;
    logic signed [VAL_W-1:0]  dx3_reg, dy3_reg;
    logic [VAL_W-1:0]         den3_reg;
    logic [ELAST_W:0]         e3_reg;
    logic                     v3_reg;

    always_comb
    begin
        logic signed [51:0] s;
        s        = 52'(pvx2_reg) + 52'(pvy2_reg);
        vn3_next = 36'(s >>> Q_FRAC);
    end

    // ---------------- stage 4: impulse numerator and split numerators
    body_t                    b4_reg;
    logic signed [54:0]       jp4_reg;
    logic signed [63:0]       max4_reg, may4_reg, mbx4_reg, mby4_reg;
    logic [VAL_W-1:0]         den4_reg;
    logic                     v4_reg;

    // ---------------- stage 5: magnitudes, overflow test
    side_t                    sd5_reg, sd5_next;
    logic [52:0]              jmag5_reg, jmag5_next;
    logic [61:0]              max5_reg, may5_reg, mbx5_reg, mby5_reg;
    logic [61:0]              max5_next, may5_next, mbx5_next, mby5_next;
    logic [VAL_W-1:0]         den5_reg;
    logic                     v5_reg;

    function automatic logic [61:0] mag62(input logic signed [63:0] x);
        logic signed [63:0] a;
        a = (x < 0) ? -x : x;
        return a[61:0];
    endfunction

    always_comb
    begin
        logic signed [54:0] ja;
        ja               = (jp4_reg < 0) ? -jp4_reg : jp4_reg;
        jmag5_next       = ja[52:0];
        sd5_next.body    = b4_reg;
        sd5_next.jneg    = (jp4_reg < 0);
        sd5_next.jovf    = ({11'b0, ja[52:32]} >= den4_reg);
        sd5_next.neg_ax  = (max4_reg < 0);
        sd5_next.neg_ay  = (may4_reg < 0);
        sd5_next.neg_bx  = (mbx4_reg < 0);
        sd5_next.neg_by  = (mby4_reg < 0);
        max5_next        = mag62(max4_reg);
        may5_next        = mag62(may4_reg);
        mbx5_next        = mag62(mbx4_reg);
        mby5_next        = mag62(mby4_reg);
    end

    // ---------------- dividers
    logic [DIV_QW-1:0] jq, qax, qay, qbx, qby;
    side_t             sdd;
    logic [DIV_QW-1:0] vdiv_reg;

    icr_div #(.DW(VAL_W), .QW(DIV_QW), .SW(SW)) u_div_j (
        .clk(clk), .en(en), .den(den5_reg),
        .rem0({11'b0, jmag5_reg[52:32]}), .num_lo(jmag5_reg[31:0]),
        .side_in(sd5_reg), .quot(jq), .side_out(sdd)
    );
    icr_div #(.DW(VAL_W), .QW(DIV_QW), .SW(1)) u_div_ax (
        .clk(clk), .en(en), .den(den5_reg),
        .rem0({2'b0, max5_reg[61:32]}), .num_lo(max5_reg[31:0]),
        .side_in(1'b0), .quot(qax), .side_out()
    );
    icr_div #(.DW(VAL_W), .QW(DIV_QW), .SW(1)) u_div_ay (
        .clk(clk), .en(en), .den(den5_reg),
        .rem0({2'b0, may5_reg[61:32]}), .num_lo(may5_reg[31:0]),
        .side_in(1'b0), .quot(qay), .side_out()
    );
    icr_div #(.DW(VAL_W), .QW(DIV_QW), .SW(1)) u_div_bx (
        .clk(clk), .en(en), .den(den5_reg),
        .rem0({2'b0, mbx5_reg[61:32]}), .num_lo(mbx5_reg[31:0]),
        .side_in(1'b0), .quot(qbx), .side_out()
    );
    icr_div #(.DW(VAL_W), .QW(DIV_QW), .SW(1)) u_div_by (
        .clk(clk), .en(en), .den(den5_reg),
        .rem0({2'b0, mby5_reg[61:32]}), .num_lo(mby5_reg[31:0]),
        .side_in(1'b0), .quot(qby), .side_out()
    );

    // ---------------- stage 6: signed impulse and position corrections
    body_t                    b6_reg;
    logic signed [VAL_W-1:0]  j6_reg, j6_next;
    logic signed [VAL_W-1:0]  sax6_reg, say6_reg, sbx6_reg, sby6_reg;
    logic signed [VAL_W-1:0]  sax6_next, say6_next, sbx6_next, sby6_next;
    logic                     v6_reg;

    function automatic logic signed [63:0] apply_sign(input logic neg,
                                                      input logic [DIV_QW-1:0] q);
        logic signed [63:0] a;
        a = $signed({32'b0, q});
        return neg ? -a : a;
    endfunction

    always_comb
    begin
        if (sdd.jovf)
            j6_next = sdd.jneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            j6_next = sat32(apply_sign(sdd.jneg, jq));
        sbx6_next = sat32(apply_sign(sdd.neg_bx, qbx));
        sby6_next = sat32(apply_sign(sdd.neg_by, qby));
        sax6_next = sat32(-apply_sign(sdd.neg_ax, qax));
        say6_next = sat32(-apply_sign(sdd.neg_ay, qay));
    end

    // ---------------- stage 7: impulse along the normal
    body_t                    b7_reg;
    logic signed [49:0]       pjx7_reg, pjy7_reg;
    logic signed [VAL_W-1:0]  sax7_reg, say7_reg, sbx7_reg, sby7_reg;
    logic                     v7_reg;

    // ---------------- stage 8: impulse vector
    body_t                    b8_reg;
    logic signed [VAL_W-1:0]  fx8_reg, fy8_reg;
    logic signed [VAL_W-1:0]  sax8_reg, say8_reg, sbx8_reg, sby8_reg;
    logic                     v8_reg;

    // ---------------- stage 9: velocity deltas
    body_t                    b9_reg;
    logic signed [63:0]       dax9_reg, day9_reg, dbx9_reg, dby9_reg;
    logic signed [VAL_W-1:0]  sax9_reg, say9_reg, sbx9_reg, sby9_reg;
    logic                     v9_reg;

    // ---------------- stage 10: output register
    logic [OUT_W-1:0] out_reg, out_next;
    logic             stat_reg;
    logic             out_valid_reg;

    always_comb
    begin
        logic signed [63:0] ax, ay, bx, by;
        ax = 64'(b9_reg.va_x) + (dax9_reg >>> Q_FRAC);
        ay = 64'(b9_reg.va_y) + (day9_reg >>> Q_FRAC);
        bx = 64'(b9_reg.vb_x) - (dbx9_reg >>> Q_FRAC);
        by = 64'(b9_reg.vb_y) - (dby9_reg >>> Q_FRAC);
        if (b9_reg.stat)
            out_next = {128'b0, b9_reg.vb_y, b9_reg.vb_x, b9_reg.va_y, b9_reg.va_x};
        else
            out_next = {sby9_reg, sbx9_reg, say9_reg, sax9_reg,
                        sat32(by), sat32(bx), sat32(ay), sat32(ax)};
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            vdiv_reg      <= '0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            v9_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= s_tvalid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            vdiv_reg      <= {vdiv_reg[DIV_QW-2:0], v5_reg};
            v6_reg        <= vdiv_reg[DIV_QW-1];
            v7_reg        <= v6_reg;
            v8_reg        <= v7_reg;
            v9_reg        <= v8_reg;
            out_valid_reg <= v9_reg;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_reg   <= b1_next;
            dvx1_reg <= dvx1_next;
            dvy1_reg <= dvy1_next;
            den1_reg <= den1_next;
            e1_reg   <= e1_next;
            dep1_reg <= dep1_next;

            b2_reg   <= b1_reg;
            pvx2_reg <= dvx1_reg * 51'(b1_reg.nx);
            pvy2_reg <= dvy1_reg * 51'(b1_reg.ny);
            pdx2_reg <= $signed({1'b0, dep1_reg}) * 50'(b1_reg.nx);
            pdy2_reg <= $signed({1'b0, dep1_reg}) * 50'(b1_reg.ny);
            den2_reg <= den1_reg;
            e2_reg   <= e1_reg;

            b3_reg   <= b2_reg;
            vn3_reg  <= vn3_next;
            dx3_reg  <= sat32(64'(pdx2_reg >>> Q_FRAC));
            dy3_reg  <= sat32(64'(pdy2_reg >>> Q_FRAC));
            den3_reg <= den2_reg;
            e3_reg   <= e2_reg;

            b4_reg   <= b3_reg;
            jp4_reg  <= $signed({1'b0, e3_reg}) * 55'(vn3_reg);
            max4_reg <= 64'(dx3_reg) * $signed({33'b0, b3_reg.ia});
            may4_reg <= 64'(dy3_reg) * $signed({33'b0, b3_reg.ia});
            mbx4_reg <= 64'(dx3_reg) * $signed({33'b0, b3_reg.ib});
            mby4_reg <= 64'(dy3_reg) * $signed({33'b0, b3_reg.ib});
            den4_reg <= den3_reg;

            sd5_reg   <= sd5_next;
            jmag5_reg <= jmag5_next;
            max5_reg  <= max5_next;
            may5_reg  <= may5_next;
            mbx5_reg  <= mbx5_next;
            mby5_reg  <= mby5_next;
            den5_reg  <= den4_reg;

            b6_reg   <= sdd.body;
            j6_reg   <= j6_next;
            sax6_reg <= sax6_next;
            say6_reg <= say6_next;
            sbx6_reg <= sbx6_next;
            sby6_reg <= sby6_next;

            b7_reg   <= b6_reg;
            pjx7_reg <= 50'(j6_reg) * 50'(b6_reg.nx);
            pjy7_reg <= 50'(j6_reg) * 50'(b6_reg.ny);
            sax7_reg <= sax6_reg;
            say7_reg <= say6_reg;
            sbx7_reg <= sbx6_reg;
            sby7_reg <= sby6_reg;

            b8_reg   <= b7_reg;
            fx8_reg  <= sat32(64'(pjx7_reg >>> Q_FRAC));
            fy8_reg  <= sat32(64'(pjy7_reg >>> Q_FRAC));
            sax8_reg <= sax7_reg;
            say8_reg <= say7_reg;
            sbx8_reg <= sbx7_reg;
            sby8_reg <= sby7_reg;

            b9_reg   <= b8_reg;
            dax9_reg <= 64'(fx8_reg) * $signed({33'b0, b8_reg.ia});
            day9_reg <= 64'(fy8_reg) * $signed({33'b0, b8_reg.ia});
            dbx9_reg <= 64'(fx8_reg) * $signed({33'b0, b8_reg.ib});
            dby9_reg <= 64'(fy8_reg) * $signed({33'b0, b8_reg.ib});
            sax9_reg <= sax8_reg;
            say9_reg <= say8_reg;
            sbx9_reg <= sbx8_reg;
            sby9_reg <= sby8_reg;

            out_reg  <= out_next;
            stat_reg <= b9_reg.stat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = stat_reg;

endmodule

/* rtl/icr_checker.sv */
// Port-level checks for the impulse collision response top level, with its bind.
// Depends on icr_pkg.
module icr_checker
    import icr_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [IN_W-1:0]  s_tdata,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tuser
);

    // hold a stalled result
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // input side advances exactly when the output register can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // both bodies static: no position correction
    a_static: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[OUT_W-1:OUT_W/2] == '0)
        else $error("static pair reports a correction");

endmodule

bind impulse_collision_response_top icr_checker u_icr_checker (.*);
